@@ sv/rgba_box_downsample_4x4_assert.svh @@
// ----------------------------------------------------------------------------
// rgba box downsampler assertion macros
// Concurrent assertion helpers clocked on clk_i, held off during rst_ni.
// ----------------------------------------------------------------------------
`ifndef RGBA_BOX_DOWNSAMPLE_4X4_ASSERT_SVH
`define RGBA_BOX_DOWNSAMPLE_4X4_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define RBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rbd: property violated");
// condition must never be seen at a clock edge out of reset
`define RBD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rbd: forbidden condition seen");
`else
`define RBD_ASSERT(lbl, prop)
`define RBD_NEVER(lbl, cond)
`endif
`endif

@@ sv/rbd4_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd4_pkg
// Shared constants for the 4x4 rgba box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd4_pkg;

  // default source line capacity in pixels
  localparam int unsigned MaxWidthDefault = 1024;
  // tallest supported source image
  localparam int unsigned MaxHeight       = 4096;

  // channel and field widths
  localparam int unsigned ChanW    = 8;
  localparam int unsigned SumW     = 12;
  localparam int unsigned EntryW   = 4 * SumW;
  localparam int unsigned PixelW   = 4 * ChanW;
  localparam int unsigned OutColW  = 8;
  localparam int unsigned OutRowW  = 10;
  localparam int unsigned RowW     = 12;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned ImgWidW  = 11;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 56;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  // register reset values
  localparam int unsigned ImageWidthReset  = 640;
  localparam int unsigned ImageHeightReset = 480;

  // one finished output pixel
  typedef struct packed {
    logic                 last;
    logic [OutRowW-1:0]   row;
    logic [OutColW-1:0]   column;
    logic [ChanW-1:0]     alpha;
    logic [ChanW-1:0]     blue;
    logic [ChanW-1:0]     green;
    logic [ChanW-1:0]     red;
  } result_t;

endpackage

`default_nettype wire

@@ sv/rgba_box_downsample_4x4.sv @@
// ----------------------------------------------------------------------------
// rgba_box_downsample_4x4
// Streaming 4x4 box-filter downsampler for raster-order rgba pixels.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock and returns one averaged pixel per 4x4
// block, formed on the block's bottom-right source pixel and offered on the
// output from the clock edge after the one that takes that pixel. Per-column-
// group partial sums live in a single-port-write, registered-read memory of
// MAX_WIDTH/4 entries; every in-block pixel does one read-modify-write of its
// entry, with a bypass register covering the back-to-back case of two pixels
// in the same group. Results go through a two-entry output queue. Input ready
// drops while that queue is full, or while it holds one result and another
// one is being formed, so it stays low for as long as the output side stalls
// a full queue; with the output side ready the block sustains one pixel per
// clock. Width is clamped to 1..MAX_WIDTH and height to 1..4096 when written;
// columns and rows beyond the last full group of four are consumed without
// effect. No clearing pass is needed after reset: an entry is always first
// written at a block's top-left pixel.
`default_nettype none

module rgba_box_downsample_4x4 #(
  parameter int unsigned MAX_WIDTH = rbd4_pkg::MaxWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  wire logic [rbd4_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: frame_start[0]
  input  wire logic [0:0]                     s_axis_tuser_i,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
  //        out_column[39:32], out_row[49:40], zero fill[55:50]
  output      logic [rbd4_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tlast: frame_done
  output      logic                           m_axis_tlast_o,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rbd4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rbd4_pkg::CfgDataW-1:0]  cfg_data_i
);

  import rbd4_pkg::*;

  `include "rgba_box_downsample_4x4_assert.svh"

  localparam int unsigned Groups  = MAX_WIDTH / 4;
  localparam int unsigned ColW    = $clog2(MAX_WIDTH);
  localparam int unsigned IdxW    = (ColW > 2) ? ColW - 2 : 1;
  localparam int unsigned WeW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW    = (WeW > ImgWidW) ? WeW : ImgWidW;
  localparam int unsigned WidthRst =
    (ImageWidthReset > MAX_WIDTH) ? MAX_WIDTH : ImageWidthReset;

  // --------------------------------------------------------------------------
  // configuration, stored already clamped
  // --------------------------------------------------------------------------
  logic [WeW-1:0]     eff_width_q,  eff_width_d;
  logic [HeightW-1:0] eff_height_q, eff_height_d;
  logic [CmpW-1:0]    wr_width_ext;
  logic [HeightW-1:0] wr_height;

  always_comb begin
    wr_width_ext = CmpW'(cfg_data_i[ImgWidW-1:0]);
    wr_height    = cfg_data_i[HeightW-1:0];
    eff_width_d  = eff_width_q;
    eff_height_d = eff_height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth: begin
          if (wr_width_ext == '0) begin
            eff_width_d = WeW'(1);
          end else if (wr_width_ext > CmpW'(MAX_WIDTH)) begin
            eff_width_d = WeW'(MAX_WIDTH);
          end else begin
            eff_width_d = WeW'(wr_width_ext);
          end
        end
        RegImageHeight: begin
          if (wr_height == '0) begin
            eff_height_d = HeightW'(1);
          end else if (wr_height > HeightW'(MaxHeight)) begin
            eff_height_d = HeightW'(MaxHeight);
          end else begin
            eff_height_d = wr_height;
          end
        end
        default: begin
          eff_width_d  = eff_width_q;
          eff_height_d = eff_height_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_width_q  <= WeW'(WidthRst);
      eff_height_q <= HeightW'(ImageHeightReset);
    end else begin
      eff_width_q  <= eff_width_d;
      eff_height_q <= eff_height_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position of the incoming pixel and memory read
  // --------------------------------------------------------------------------
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    cur_col;
  logic [RowW-1:0]    cur_row;
  logic               s_acc;
  logic [CmpW-1:0]    col_ext;
  logic [CmpW-1:0]    groups_w;
  logic [HeightW-1:0] row_ext;
  logic [HeightW-1:0] groups_h;
  logic               in_block;
  logic               first_pos;
  logic               emit_pos;
  logic               last_pos;
  logic [IdxW-1:0]    cur_idx;

  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    cur_col   = s_axis_tuser_i[0] ? '0 : col_q;
    cur_row   = s_axis_tuser_i[0] ? '0 : row_q;
    col_ext   = CmpW'(cur_col);
    row_ext   = HeightW'(cur_row);
    groups_w  = CmpW'(eff_width_q) >> 2;
    groups_h  = eff_height_q >> 2;
    cur_idx   = IdxW'(cur_col >> 2);
    in_block  = ((col_ext >> 2) < groups_w) && ((row_ext >> 2) < groups_h);
    first_pos = (cur_col[1:0] == 2'd0) && (cur_row[1:0] == 2'd0);
    emit_pos  = (cur_col[1:0] == 2'd3) && (cur_row[1:0] == 2'd3);
    last_pos  = ((col_ext >> 2) == groups_w - CmpW'(1)) &&
                ((row_ext >> 2) == groups_h - HeightW'(1));
  end

  // raster position advance with wrap
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_acc) begin
      if (col_ext + CmpW'(1) >= CmpW'(eff_width_q)) begin
        col_d = '0;
        if (row_ext + HeightW'(1) >= eff_height_q) begin
          row_d = '0;
        end else begin
          row_d = cur_row + RowW'(1);
        end
      end else begin
        col_d = cur_col + ColW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic                s1_emit_q;
  logic                s1_first_q;
  logic                s1_last_q;
  logic [IdxW-1:0]     s1_idx_q;
  logic [OutRowW-1:0]  s1_orow_q;
  logic [PixelW-1:0]   s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= s_acc & in_block;
      s1_emit_q  <= s_acc & in_block & emit_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_first_q <= first_pos;
      s1_last_q  <= last_pos;
      s1_idx_q   <= cur_idx;
      s1_orow_q  <= OutRowW'(cur_row >> 2);
      s1_px_q    <= s_axis_tdata_i[PixelW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // column sum memory, registered read
  // --------------------------------------------------------------------------
  logic [EntryW-1:0] sums_mem [Groups];
  logic [EntryW-1:0] rdata_q;
  logic [EntryW-1:0] wr_entry;

  always_ff @(posedge clk_i) begin
    if (s_acc && in_block) begin
      rdata_q <= sums_mem[cur_idx];
    end
    if (s1_valid_q) begin
      sums_mem[s1_idx_q] <= wr_entry;
    end
  end

  // bypass for a write landing on the edge of the following read
  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_idx_q;
  logic [EntryW-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= wr_entry;
    end
  end

  // accumulate the pixel onto the group's partial sums
  logic [EntryW-1:0] base_entry;
  logic              fwd_hit;

  always_comb begin
    fwd_hit = fwd_valid_q && (fwd_idx_q == s1_idx_q);
    if (s1_first_q) begin
      base_entry = '0;
    end else if (fwd_hit) begin
      base_entry = fwd_data_q;
    end else begin
      base_entry = rdata_q;
    end
    for (int c = 0; c < 4; c++) begin
      wr_entry[c*SumW +: SumW] = base_entry[c*SumW +: SumW] +
                                 SumW'(s1_px_q[c*ChanW +: ChanW]);
    end
  end

  // --------------------------------------------------------------------------
  // two-entry output queue
  // --------------------------------------------------------------------------
  result_t    fifo_q [2];
  result_t    new_res;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fifo_cnt_q;
  logic       pop;

  always_comb begin
    new_res.red    = wr_entry[0*SumW+4 +: ChanW];
    new_res.green  = wr_entry[1*SumW+4 +: ChanW];
    new_res.blue   = wr_entry[2*SumW+4 +: ChanW];
    new_res.alpha  = wr_entry[3*SumW+4 +: ChanW];
    new_res.column = OutColW'(s1_idx_q);
    new_res.row    = s1_orow_q;
    new_res.last   = s1_last_q;
  end

  assign pop = m_axis_tvalid_o & m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (s1_emit_q) begin
      fifo_q[wr_ptr_q] <= new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (s1_emit_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fifo_cnt_q <= fifo_cnt_q + 2'(s1_emit_q) - 2'(pop);
    end
  end

  // room for the result in flight plus one more
  assign s_axis_tready_o = (fifo_cnt_q == 2'd0) ||
                           ((fifo_cnt_q == 2'd1) && !s1_emit_q);

  assign m_axis_tvalid_o = (fifo_cnt_q != 2'd0);
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;
  assign m_axis_tdata_o  = {6'd0, fifo_q[rd_ptr_q].row, fifo_q[rd_ptr_q].column,
                            fifo_q[rd_ptr_q].alpha, fifo_q[rd_ptr_q].blue,
                            fifo_q[rd_ptr_q].green, fifo_q[rd_ptr_q].red};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // output column of the last group in a row
  logic [OutColW-1:0] last_col;

  assign last_col = OutColW'(groups_w - CmpW'(1));

  `RBD_NEVER(a_queue_overflow, s1_emit_q && (fifo_cnt_q == 2'd2))
  `RBD_ASSERT(a_emit_needs_write, s1_emit_q |-> s1_valid_q)
  `RBD_ASSERT(a_tlast_col, m_axis_tvalid_o & m_axis_tlast_o |-> m_axis_tdata_o[39:32] == last_col)

endmodule

`default_nettype wire
